// ===== rtl/core/skset_pkg.sv =====
package skset_pkg;

	// Default store size and key width.
	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned KEY_BITS_DEF = 32;

	// Widths of the stream fields. These are fixed by the interface.
	localparam int unsigned OPCODE_BITS = 2;
	localparam int unsigned KEY_FIELD_BITS = 32;
	localparam int unsigned COUNT_BITS = 7;
	localparam int unsigned S_TDATA_BITS = 40;
	localparam int unsigned M_TDATA_BITS = 16;

	// Operation codes.
	typedef enum logic [OPCODE_BITS-1:0] {
		OP_CONTAINS = 2'd0,
		OP_ADD      = 2'd1,
		OP_REMOVE   = 2'd2
	} op_t;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} state_t;

	// Control that the sequencer broadcasts to every cell.
	typedef struct packed {
		logic cmp_en;
		logic signed_cmp;
		logic ins;
		logic del;
	} skset_ctrl_t;

endpackage

// ===== rtl/core/skset_cell.sv =====
module skset_cell
	import skset_pkg::*;
#(
	parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  skset_ctrl_t         ctrl,
	input  logic                occupied,
	input  logic [KEY_BITS-1:0] cmp_key,
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [KEY_BITS-1:0] left_entry,
	input  logic                left_lt,
	input  logic [KEY_BITS-1:0] right_entry,
	output logic [KEY_BITS-1:0] entry,
	output logic                lt,
	output logic                eq
);

	localparam logic [KEY_BITS-1:0] KEY_TOP = KEY_BITS'(1) << (KEY_BITS - 1);

	logic [KEY_BITS-1:0] entry_q;
	logic                lt_q;
	logic                eq_q;
	logic [KEY_BITS-1:0] flip;
	logic [KEY_BITS-1:0] ord_entry;
	logic [KEY_BITS-1:0] ord_key;

	// Flipping the top bit turns a signed order into an unsigned one.
	always_comb begin
		flip      = ctrl.signed_cmp ? KEY_TOP : '0;
		ord_entry = entry_q ^ flip;
		ord_key   = cmp_key ^ flip;
	end

	// Compare the held entry with the incoming key. Empty cells never match.
	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_q <= occupied && (ord_entry < ord_key);
			eq_q <= occupied && (ord_entry == ord_key);
		end
	end

	// The position is the first cell that does not order below the key.
	// left_lt is high when every cell to the left orders below the key, so
	// this cell is below the position when it also orders below the key,
	// and it is at the position when it does not.
	assign lt = left_lt && lt_q;
	assign eq = left_lt && eq_q;

	// Shift step: on insert, the cell at the position takes the new key and
	// cells above it take their left neighbour's entry; on remove, cells from
	// the position up take their right neighbour's entry.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (lt) begin
				entry_q <= entry_q;
			end else if (left_lt) begin
				entry_q <= new_key;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctrl.del) begin
			if (!lt) begin
				entry_q <= right_entry;
			end
		end
	end

	assign entry = entry_q;

endmodule

// ===== rtl/core/skset_chain.sv =====
module skset_chain
	import skset_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	parameter int unsigned KEY_BITS = KEY_BITS_DEF,
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  skset_ctrl_t         ctrl,
	input  logic [CNT_W-1:0]    count,
	input  logic [KEY_BITS-1:0] cmp_key,
	input  logic [KEY_BITS-1:0] new_key,
	output logic                hit
);

	logic [KEY_BITS-1:0] entries [CAPACITY];
	logic [CAPACITY-1:0] lt_vec;
	logic [CAPACITY-1:0] eq_vec;

	// One cell for each slot; each sees its two neighbours. The first cell
	// has nothing to its left, so everything to its left orders below.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0] left_entry;
		logic                left_lt;
		logic [KEY_BITS-1:0] right_entry;

		if (i == 0) begin : g_first
			assign left_entry = new_key;
			assign left_lt    = 1'b1;
		end else begin : g_mid
			assign left_entry = entries[i-1];
			assign left_lt    = lt_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = entries[i];
		end else begin : g_inner
			assign right_entry = entries[i+1];
		end

		skset_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (CNT_W'(i) < count),
			.cmp_key    (cmp_key),
			.new_key    (new_key),
			.left_entry (left_entry),
			.left_lt    (left_lt),
			.right_entry(right_entry),
			.entry      (entries[i]),
			.lt         (lt_vec[i]),
			.eq         (eq_vec[i])
		);
	end

	// The key is present if the cell at the position matched.
	assign hit = |eq_vec;

endmodule

// ===== rtl/core/sorted_key_set.sv =====
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata: opcode[1:0], key[33:2]
// m_*       out        m_tvalid / m_tready  tdata: found[0], full_reject[1], count[8:2]
// cfg_*     in         cfg_we               cfg_wdata: compare_signed
//
// Each item is handled in a compare step, in which every cell compares its entry
// with the key, and then a shift step, in which the cells shift together to insert
// or remove. The shift step waits while the previous result is still held on m_*.
// A new item is accepted as soon as the shift is done, even if the result
// has not yet been taken. Reset empties the set and clears the ordering
// register; stored keys themselves are not cleared.
module sorted_key_set
	import skset_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,  // opcode, key
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata,  // found, full_reject, count
	input  logic                    cfg_we,
	input  logic                    cfg_wdata
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	state_t              state_q;
	state_t              state_d;
	logic                signed_q;
	logic [CNT_W-1:0]    count_q;
	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q;
	logic                m_tvalid_q;
	logic                found_q;
	logic                reject_q;
	logic [CNT_W-1:0]    count_out_q;

	logic                          accept;
	logic                          go;
	logic                          hit;
	logic                          full;
	logic                          do_ins;
	logic                          do_del;
	logic                          reject;
	skset_ctrl_t                   ctrl;
	logic [KEY_BITS+KEY_FIELD_BITS-1:0] key_ext;
	logic [KEY_BITS-1:0]           in_key;
	logic [CNT_W+COUNT_BITS-1:0]   cnt_ext;

	// Incoming key, taken in its low KEY_BITS bits.
	assign key_ext = {{KEY_BITS{1'b0}}, s_tdata[OPCODE_BITS +: KEY_FIELD_BITS]};
	assign in_key  = key_ext[KEY_BITS-1:0];
	assign accept  = s_tvalid && s_tready;
	assign full    = count_q >= CNT_W'(CAPACITY);

	// Decide the operation from the match result.
	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		reject = 1'b0;
		case (op_q)
			OP_ADD: begin
				do_ins = !hit && !full;
				reject = !hit && full;
			end
			OP_REMOVE: begin
				do_del = hit;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: next state and broadcast control.
	always_comb begin
		state_d         = state_q;
		s_tready        = 1'b0;
		go              = 1'b0;
		ctrl.cmp_en     = 1'b0;
		ctrl.signed_cmp = signed_q;
		ctrl.ins        = 1'b0;
		ctrl.del        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				ctrl.cmp_en = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				go = !m_tvalid_q || m_tready;
				if (go) begin
					ctrl.ins = do_ins;
					ctrl.del = do_del;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Ordering register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q <= 1'b0;
		end else if (cfg_we) begin
			signed_q <= cfg_wdata;
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(s_tdata[OPCODE_BITS-1:0]);
			key_q <= in_key;
		end
	end

	// Key count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (go && do_ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (go && do_del) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			found_q  <= hit;
			reject_q <= reject;
			if (do_ins) begin
				count_out_q <= count_q + CNT_W'(1);
			end else if (do_del) begin
				count_out_q <= count_q - CNT_W'(1);
			end else begin
				count_out_q <= count_q;
			end
		end
	end

	skset_chain #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_chain (
		.clk    (clk),
		.ctrl   (ctrl),
		.count  (count_q),
		.cmp_key(in_key),
		.new_key(key_q),
		.hit    (hit)
	);

	// Output packing.
	assign cnt_ext  = {{COUNT_BITS{1'b0}}, count_out_q};
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_BITS'({cnt_ext[COUNT_BITS-1:0], reject_q, found_q});

endmodule

// ===== rtl/core/skset_checker.sv =====
module skset_checker
	import skset_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [M_TDATA_BITS-1:0] m_tdata
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A refused insert is never reported for a present key.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("full_reject raised for a present key");

	// The count never exceeds the store size.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CAPACITY > 127) || (m_tdata[8:2] <= CAPACITY))
		else $error("count beyond capacity");

	// One item at a time: no accept in the cycle after an accept.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted during a shift");

endmodule

bind sorted_key_set skset_checker #(
	.CAPACITY(CAPACITY)
) u_skset_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== tb/sorted_key_set_test.sv =====
`timescale 1ns / 100ps

import skset_pkg::*;

// Opcode three is not in the package enum; the block treats it as a lookup.
localparam logic [OPCODE_BITS-1:0] OP_SPARE = 2'd3;

typedef struct packed {
	logic                  found;
	logic                  full_reject;
	logic [COUNT_BITS-1:0] count;
} set_reply_t;

// Mirror of the key set, with the replies it still owes.
class sorted_set_tracker;
	bit [KEY_FIELD_BITS-1:0] members[$];
	bit                      signed_order;
	set_reply_t              owed[$];
	int                      errors;

	function void complain(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// True when a orders strictly below b under the current ordering.
	function bit below(bit [KEY_FIELD_BITS-1:0] a, bit [KEY_FIELD_BITS-1:0] b);
		if (signed_order)
			return $signed(a) < $signed(b);
		return a < b;
	endfunction

	// Apply one accepted operation and queue the reply it should produce.
	function void note_item(logic [OPCODE_BITS-1:0] op, logic [KEY_FIELD_BITS-1:0] key);
		int         pos;
		bit         hit;
		bit         stop;
		set_reply_t reply;
		pos = 0;
		hit = 1'b0;
		stop = 1'b0;
		// Scan up to the first entry that is not below the key.
		while (!stop && pos < members.size()) begin
			if (members[pos] == key) begin
				hit = 1'b1;
				stop = 1'b1;
			end else if (below(key, members[pos])) begin
				stop = 1'b1;
			end else begin
				pos++;
			end
		end
		reply.found = hit;
		reply.full_reject = 1'b0;
		if (op == OP_ADD && !hit) begin
			if (members.size() >= CAPACITY_DEF)
				reply.full_reject = 1'b1;
			else
				members.insert(pos, key);
		end else if (op == OP_REMOVE && hit) begin
			members.delete(pos);
		end
		reply.count = COUNT_BITS'(members.size());
		owed.push_back(reply);
	endfunction

	// Compare one delivered reply with the oldest one owed.
	function void check_result(logic [M_TDATA_BITS-1:0] word);
		set_reply_t want;
		if (owed.size() == 0) begin
			complain($sformatf("result %h arrived with nothing outstanding", word));
			return;
		end
		want = owed.pop_front();
		if (word[0] !== want.found)
			complain($sformatf("found: expected %b, got %b", want.found, word[0]));
		if (word[1] !== want.full_reject)
			complain($sformatf("full_reject: expected %b, got %b",
				want.full_reject, word[1]));
		if (word[8:2] !== want.count)
			complain($sformatf("count: expected %0d, got %0d", want.count, word[8:2]));
	endfunction
endclass

module sorted_key_set_test;

	localparam int POOL_SIZE = 72;
	localparam int STALL_LIMIT = 5000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic                    cfg_we = 1'b0;
	logic                    cfg_wdata = 1'b0;

	sorted_set_tracker       tracker;
	bit [KEY_FIELD_BITS-1:0] pool[POOL_SIZE];
	int                      send_idle_pct = 7;
	int                      recv_idle_pct = 76;
	int                      quiet_cycles = 0;

	sorted_key_set dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Both handshakes are observed here, so the mirror sees items in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_item(s_tdata[1:0], s_tdata[33:2]);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata);
		end
	end

	// Give up once neither side has moved an item for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one item, with random gaps ahead of it, and return at the
	// falling edge after it has been taken. Valid is left high.
	task automatic send_item(input logic [OPCODE_BITS-1:0] op,
			input logic [KEY_FIELD_BITS-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_BITS - KEY_FIELD_BITS - OPCODE_BITS){1'b0}}, key, op};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	// Change the key ordering once the block has delivered everything.
	task automatic write_order(input logic signed_keys);
		s_tvalid <= 1'b0;
		while (tracker.owed.size() != 0)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= signed_keys;
		@(posedge clk);
		tracker.signed_order = signed_keys;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Remove every key held, so that a new ordering starts from an empty set.
	task automatic empty_set();
		bit [KEY_FIELD_BITS-1:0] held[$];
		held = tracker.members;
		foreach (held[i])
			send_item(OP_REMOVE, held[i]);
	endtask

	// Build a pool of distinct keys, led by the extremes of both orderings.
	task automatic make_pool();
		bit [KEY_FIELD_BITS-1:0] cand;
		bit                      dup;
		pool[0] = 32'h0000_0000;
		pool[1] = 32'hFFFF_FFFF;
		pool[2] = 32'h8000_0000;
		pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++) begin
			do begin
				cand = $urandom;
				if ($urandom_range(3) == 0)
					cand = cand & 32'h8000_00FF;
				dup = 1'b0;
				for (int j = 0; j < i; j++)
					if (pool[j] == cand)
						dup = 1'b1;
			end while (dup);
			pool[i] = cand;
		end
	endtask

	// Mixed operations, mostly on pool keys so that hits are common.
	task automatic random_items(input int n);
		int                      roll;
		logic [OPCODE_BITS-1:0]  op;
		logic [KEY_FIELD_BITS-1:0] key;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 35)
				op = OP_ADD;
			else if (roll < 70)
				op = OP_REMOVE;
			else if (roll < 95)
				op = OP_CONTAINS;
			else
				op = OP_SPARE;
			if ($urandom_range(99) < 85)
				key = pool[$urandom_range(POOL_SIZE - 1)];
			else
				key = $urandom;
			send_item(op, key);
		end
	endtask

	// Insert the whole pool, with some noise, so that the set runs full
	// and the last adds are refused.
	task automatic fill_set();
		foreach (pool[i]) begin
			if ($urandom_range(99) < 20)
				random_items(1);
			send_item(OP_ADD, pool[i]);
		end
	endtask

	task automatic run_phase();
		make_pool();
		fill_set();
		random_items(80);
		s_tvalid <= 1'b0;
	endtask

	initial begin
		tracker = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Unsigned ordering: empty set, extremes, duplicates and misses.
		write_order(1'b0);
		send_item(OP_CONTAINS, 32'h0000_0000);
		send_item(OP_REMOVE, 32'h0000_0005);
		send_item(OP_ADD, 32'h0000_0000);
		send_item(OP_ADD, 32'hFFFF_FFFF);
		send_item(OP_ADD, 32'h8000_0000);
		send_item(OP_ADD, 32'h7FFF_FFFF);
		send_item(OP_ADD, 32'h0000_0000);
		send_item(OP_CONTAINS, 32'hFFFF_FFFF);
		send_item(OP_SPARE, 32'h8000_0000);
		send_item(OP_SPARE, 32'h0000_1234);
		send_item(OP_REMOVE, 32'h8000_0000);
		send_item(OP_REMOVE, 32'h8000_0000);
		send_item(OP_CONTAINS, 32'h8000_0000);
		send_item(OP_ADD, 32'h0000_0001);
		send_item(OP_ADD, 32'hFFFF_FFFE);
		send_item(OP_REMOVE, 32'h0000_0000);
		send_item(OP_REMOVE, 32'hFFFF_FFFF);
		empty_set();

		// Signed ordering: negative keys must sort below positive ones.
		write_order(1'b1);
		send_item(OP_ADD, 32'h8000_0000);
		send_item(OP_ADD, 32'h7FFF_FFFF);
		send_item(OP_ADD, 32'hFFFF_FFFF);
		send_item(OP_ADD, 32'h0000_0000);
		send_item(OP_ADD, 32'h0000_0001);
		send_item(OP_CONTAINS, 32'h8000_0000);
		send_item(OP_REMOVE, 32'hFFFF_FFFF);

		// Sender rarely idles, receiver mostly stalls.
		run_phase();
		@(negedge clk);
		empty_set();
		write_order(1'b0);

		// Sender mostly idles, receiver rarely stalls.
		send_idle_pct = 76;
		recv_idle_pct = 7;
		run_phase();
		@(negedge clk);
		empty_set();
		write_order(1'b1);

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase();

		while (tracker.owed.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.owed.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
